### rtl/core/chip8_instruction_execute_defines.svh
// Assertion macros shared by the CHIP-8 execute block.
// Included by the top level; depends on nothing else.
`ifndef CHIP8_INSTRUCTION_EXECUTE_DEFINES_SVH
`define CHIP8_INSTRUCTION_EXECUTE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define C8IE_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define C8IE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/core/chip8ie_pkg.sv
// Types and constants of the CHIP-8 execute block.
// Used by the register file, the ALU and the top level of the block; depends on nothing.
package chip8ie_pkg;

   // Top nibble of the opcode.
   localparam logic [3:0] OP_SYS   = 4'h0;
   localparam logic [3:0] OP_JP    = 4'h1;
   localparam logic [3:0] OP_CALL  = 4'h2;
   localparam logic [3:0] OP_SE_KK = 4'h3;
   localparam logic [3:0] OP_SN_KK = 4'h4;
   localparam logic [3:0] OP_SE_XY = 4'h5;
   localparam logic [3:0] OP_LD_KK = 4'h6;
   localparam logic [3:0] OP_AD_KK = 4'h7;
   localparam logic [3:0] OP_ALU   = 4'h8;
   localparam logic [3:0] OP_SN_XY = 4'h9;
   localparam logic [3:0] OP_LD_I  = 4'hA;
   localparam logic [3:0] OP_JP_V0 = 4'hB;
   localparam logic [3:0] OP_RND   = 4'hC;
   localparam logic [3:0] OP_MISC  = 4'hF;

   // Low nibble of the 8xyN group.
   localparam logic [3:0] ALU_MOV = 4'h0;
   localparam logic [3:0] ALU_OR  = 4'h1;
   localparam logic [3:0] ALU_AND = 4'h2;
   localparam logic [3:0] ALU_XOR = 4'h3;
   localparam logic [3:0] ALU_ADD = 4'h4;
   localparam logic [3:0] ALU_SUB = 4'h5;
   localparam logic [3:0] ALU_SHR = 4'h6;
   localparam logic [3:0] ALU_SBN = 4'h7;
   localparam logic [3:0] ALU_SHL = 4'hE;

   localparam logic [11:0] NNN_RET     = 12'h0EE;
   localparam logic [7:0]  KK_ADD_I    = 8'h1E;
   localparam logic [3:0]  REG_VF      = 4'hF;
   localparam logic [3:0]  REG_V0      = 4'h0;
   localparam logic [11:0] PC_RESET    = 12'h200;
   localparam logic [11:0] PC_STEP     = 12'd2;
   localparam logic [11:0] PC_SKIP     = 12'd4;

   // Register file write request from the execute stage.
   typedef struct packed {
      logic       wr;
      logic [3:0] x;
      logic [7:0] res;
      logic       fw;
      logic       flag;
   } rf_wr_type;

   // Everything one instruction decides.
   typedef struct packed {
      logic [11:0] next_pc;
      logic [11:0] link_pc;
      logic [15:0] index;
      logic        push;
      logic        pop;
      rf_wr_type   rf;
      logic        unh;
   } exec_type;

   // Result item payload.
   typedef struct packed {
      logic [11:0] next_pc;
      logic [15:0] index_value;
      logic        reg_written;
      logic [3:0]  reg_number;
      logic [7:0]  reg_value;
      logic        flag_written;
      logic        flag_value;
      logic        unhandled;
   } rsp_type;

endpackage

### rtl/core/chip8ie_if.sv
// Valid/ready channel interfaces for the CHIP-8 execute block.
// Standalone; no package dependency.

// Opcode channel: one fetched instruction per item.
interface chip8ie_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] opcode;
   logic [7:0]  random_byte;

   modport source (output valid, output opcode, output random_byte, input ready);
   modport sink (input valid, input opcode, input random_byte, output ready);
endinterface

// Result channel: one item per executed instruction.
interface chip8ie_rsp_if;
   logic        valid;
   logic        ready;
   logic [11:0] next_pc;
   logic [15:0] index_value;
   logic        reg_written;
   logic [3:0]  reg_number;
   logic [7:0]  reg_value;
   logic        flag_written;
   logic        flag_value;
   logic        unhandled;

   modport source (output valid, output next_pc, output index_value, output reg_written,
                   output reg_number, output reg_value, output flag_written,
                   output flag_value, output unhandled, input ready);
   modport sink (input valid, input next_pc, input index_value, input reg_written,
                 input reg_number, input reg_value, input flag_written,
                 input flag_value, input unhandled, output ready);
endinterface

### rtl/core/chip8ie_regfile.sv
// General register file V0..VF: memory with registered reads plus VF and V0 registers.
// Depends on chip8ie_pkg.
module chip8ie_regfile (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   rd_en,
   input  logic [3:0]             rd_x,
   input  logic [3:0]             rd_y,
   input  chip8ie_pkg::rf_wr_type wr,
   output logic [7:0]             vx,
   output logic [7:0]             vy,
   output logic [7:0]             v0
);

   logic [7:0]  mem [16];
   logic [15:0] valid_ff;
   logic [15:0] valid_in;
   logic [7:0]  rx_ff;
   logic [7:0]  ry_ff;
   logic        x_vf_ff;
   logic        y_vf_ff;
   logic [7:0]  vf_ff;
   logic [7:0]  vf_in;
   logic [7:0]  v0_ff;
   logic [7:0]  v0_in;

   // Write port and registered read ports, with write-first bypass.
   always_ff @(posedge clock) begin
      if (wr.wr) begin
         mem[wr.x] <= wr.res;
      end
      if (rd_en) begin
         if (wr.wr && wr.x == rd_x) begin
            rx_ff <= wr.res;
         end else begin
            rx_ff <= valid_ff[rd_x] ? mem[rd_x] : 8'd0;
         end
         if (wr.wr && wr.x == rd_y) begin
            ry_ff <= wr.res;
         end else begin
            ry_ff <= valid_ff[rd_y] ? mem[rd_y] : 8'd0;
         end
         x_vf_ff <= (rd_x == chip8ie_pkg::REG_VF);
         y_vf_ff <= (rd_y == chip8ie_pkg::REG_VF);
      end
   end

   // Next values of the valid bits and of the VF and V0 registers.
   always_comb begin
      valid_in = valid_ff;
      if (wr.wr) begin
         valid_in[wr.x] = 1'b1;
      end
      vf_in = vf_ff;
      if (wr.fw) begin
         vf_in = {7'd0, wr.flag};
      end else if (wr.wr && wr.x == chip8ie_pkg::REG_VF) begin
         vf_in = wr.res;
      end
      v0_in = v0_ff;
      if (wr.wr && wr.x == chip8ie_pkg::REG_V0) begin
         v0_in = wr.res;
      end
   end

   // Control state; VF and V0 reset to zero with the rest of the file.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         vf_ff    <= 8'd0;
         v0_ff    <= 8'd0;
      end else begin
         valid_ff <= valid_in;
         vf_ff    <= vf_in;
         v0_ff    <= v0_in;
      end
   end

   // VF always comes from its own register, which holds the flag writes.
   assign vx = x_vf_ff ? vf_ff : rx_ff;
   assign vy = y_vf_ff ? vf_ff : ry_ff;
   assign v0 = v0_ff;

endmodule

### rtl/core/chip8ie_stack.sv
// Subroutine return stack: memory, wrapping pointer and a registered top entry.
// Depends on nothing outside this file.
module chip8ie_stack #(
   parameter int STACK_DEPTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   input  logic        pop,
   input  logic [11:0] push_data,
   output logic [11:0] top
);

   localparam int SP_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam logic [SP_W-1:0] SP_LAST = SP_W'(STACK_DEPTH - 1);

   logic [11:0]     mem [STACK_DEPTH];
   logic [SP_W-1:0] sp_ff;
   logic [SP_W-1:0] sp_in;
   logic [SP_W-1:0] sp_after;
   logic [SP_W-1:0] rd_addr;
   logic [11:0]     top_ff;

   // Pointer moves modulo the depth in both directions.
   always_comb begin
      sp_in = sp_ff;
      if (push) begin
         sp_in = (sp_ff == SP_LAST) ? '0 : sp_ff + SP_W'(1);
      end else if (pop) begin
         sp_in = (sp_ff == '0) ? SP_LAST : sp_ff - SP_W'(1);
      end
      sp_after = reset ? '0 : sp_in;
      rd_addr  = (sp_after == '0) ? SP_LAST : sp_after - SP_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sp_ff <= '0;
      end else begin
         sp_ff <= sp_in;
      end
   end

   // Keep the entry below the pointer ready for the next return.
   always_ff @(posedge clock) begin
      if (push) begin
         mem[sp_ff] <= push_data;
      end
      if (push && sp_ff == rd_addr) begin
         top_ff <= push_data;
      end else begin
         top_ff <= mem[rd_addr];
      end
   end

   assign top = top_ff;

endmodule

### rtl/core/chip8ie_alu.sv
// Instruction decoder and datapath for one opcode against the current state.
// Depends on chip8ie_pkg.
module chip8ie_alu (
   input  logic [15:0]           opcode,
   input  logic [7:0]            random_byte,
   input  logic [7:0]            vx,
   input  logic [7:0]            vy,
   input  logic [7:0]            v0,
   input  logic [11:0]           pc,
   input  logic [15:0]           index,
   input  logic [11:0]           stack_top,
   output chip8ie_pkg::exec_type ex
);

   logic [3:0]  hi;
   logic [3:0]  n;
   logic [11:0] nnn;
   logic [7:0]  kk;
   logic [8:0]  sum;
   logic        skip;
   logic [11:0] pc_step;

   assign hi      = opcode[15:12];
   assign n       = opcode[3:0];
   assign nnn     = opcode[11:0];
   assign kk      = opcode[7:0];
   assign sum     = {1'b0, vx} + {1'b0, vy};
   assign pc_step = pc + chip8ie_pkg::PC_STEP;

   always_comb begin
      ex         = '0;
      ex.next_pc = pc_step;
      ex.link_pc = pc_step;
      ex.index   = index;
      ex.rf.x    = opcode[11:8];
      skip       = 1'b0;
      unique case (hi)
         chip8ie_pkg::OP_SYS: begin
            if (nnn == chip8ie_pkg::NNN_RET) begin
               ex.pop     = 1'b1;
               ex.next_pc = stack_top;
            end else begin
               ex.unh = 1'b1;
            end
         end
         chip8ie_pkg::OP_JP: ex.next_pc = nnn;
         chip8ie_pkg::OP_CALL: begin
            ex.push    = 1'b1;
            ex.next_pc = nnn;
         end
         chip8ie_pkg::OP_SE_KK: skip = (vx == kk);
         chip8ie_pkg::OP_SN_KK: skip = (vx != kk);
         chip8ie_pkg::OP_SE_XY: skip = (vx == vy);
         chip8ie_pkg::OP_SN_XY: skip = (vx != vy);
         chip8ie_pkg::OP_LD_KK: begin
            ex.rf.wr  = 1'b1;
            ex.rf.res = kk;
         end
         chip8ie_pkg::OP_AD_KK: begin
            ex.rf.wr  = 1'b1;
            ex.rf.res = vx + kk;
         end
         chip8ie_pkg::OP_ALU: begin
            ex.rf.wr = 1'b1;
            case (n)
               chip8ie_pkg::ALU_MOV: ex.rf.res = vy;
               chip8ie_pkg::ALU_OR:  ex.rf.res = vx | vy;
               chip8ie_pkg::ALU_AND: ex.rf.res = vx & vy;
               chip8ie_pkg::ALU_XOR: ex.rf.res = vx ^ vy;
               chip8ie_pkg::ALU_ADD: begin
                  ex.rf.res  = sum[7:0];
                  ex.rf.fw   = 1'b1;
                  ex.rf.flag = sum[8];
               end
               chip8ie_pkg::ALU_SUB: begin
                  ex.rf.res  = vx - vy;
                  ex.rf.fw   = 1'b1;
                  ex.rf.flag = (vx >= vy);
               end
               chip8ie_pkg::ALU_SHR: begin
                  ex.rf.res  = {1'b0, vx[7:1]};
                  ex.rf.fw   = 1'b1;
                  ex.rf.flag = vx[0];
               end
               chip8ie_pkg::ALU_SBN: begin
                  ex.rf.res  = vy - vx;
                  ex.rf.fw   = 1'b1;
                  ex.rf.flag = (vy >= vx);
               end
               chip8ie_pkg::ALU_SHL: begin
                  ex.rf.res  = {vx[6:0], 1'b0};
                  ex.rf.fw   = 1'b1;
                  ex.rf.flag = vx[7];
               end
               default: begin
                  ex.rf.wr = 1'b0;
                  ex.unh   = 1'b1;
               end
            endcase
         end
         chip8ie_pkg::OP_LD_I: ex.index = {4'd0, nnn};
         chip8ie_pkg::OP_JP_V0: ex.next_pc = {4'd0, v0} + nnn;
         chip8ie_pkg::OP_RND: begin
            ex.rf.wr  = 1'b1;
            ex.rf.res = random_byte & kk;
         end
         chip8ie_pkg::OP_MISC: begin
            if (kk == chip8ie_pkg::KK_ADD_I) begin
               ex.index = index + {8'd0, vx};
            end else begin
               ex.unh = 1'b1;
            end
         end
         default: ex.unh = 1'b1;
      endcase
      if (skip) begin
         ex.next_pc = pc + chip8ie_pkg::PC_SKIP;
      end
      // Result fields read as zero when nothing is written.
      if (!ex.rf.wr) begin
         ex.rf.x   = 4'd0;
         ex.rf.res = 8'd0;
      end
   end

endmodule

### rtl/core/chip8_instruction_execute.sv
// CHIP-8 execute block: input register, execute stage, result register.
// Depends on chip8ie_pkg, chip8ie_if, chip8ie_regfile, chip8ie_stack, chip8ie_alu
// and the assertion macros in chip8_instruction_execute_defines.svh.
//
// Usage:
//  req_ch carries one fetched opcode and a random byte per item; rsp_ch returns
//  one item per opcode: the new pc, the index register, the general register
//  and VF writes, and an unhandled bit for opcodes that only advance the pc.
//  An accepted item passes the input register and then the result register on its way to rsp_ch.
//  One item per cycle is sustained while rsp_ch is ready; each opcode sees the state left by the
//  previous one because register reads are bypassed from the execute stage.
//  The register file reads happen when an item is taken into the input register,
//  and the return address is kept pre-read from the stack memory.
//  When rsp_ch stalls, the result register holds; one more item still enters
//  the input register, after which req_ch.ready drops until the result drains.
//  Synchronous reset empties both stages, clears V0..VF, the index register
//  and the stack pointer, and sets the pc to 0x200. No clearing pass is needed.
`include "chip8_instruction_execute_defines.svh"

module chip8_instruction_execute #(
   parameter int STACK_DEPTH = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   chip8ie_req_if.sink          req_ch,
   chip8ie_rsp_if.source        rsp_ch
);

   logic                  in_valid_ff;
   logic [15:0]           op_ff;
   logic [7:0]            rnd_ff;
   logic                  req_fire;
   logic                  exec_fire;
   logic [11:0]           pc_ff;
   logic [15:0]           index_ff;
   logic                  rsp_valid_ff;
   chip8ie_pkg::rsp_type  rsp_ff;
   chip8ie_pkg::rsp_type  rsp_in;
   chip8ie_pkg::exec_type ex;
   chip8ie_pkg::rf_wr_type rf_wr;
   logic [7:0]            vx;
   logic [7:0]            vy;
   logic [7:0]            v0;
   logic [11:0]           stack_top;

   // Handshake: execute when the result register is free or draining.
   assign exec_fire    = in_valid_ff && (!rsp_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !in_valid_ff || exec_fire;
   assign req_fire     = req_ch.valid && req_ch.ready;

   // Input register payload.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         op_ff  <= req_ch.opcode;
         rnd_ff <= req_ch.random_byte;
      end
   end

   // Register file writes only when the instruction really executes.
   always_comb begin
      rf_wr = ex.rf;
      if (!exec_fire) begin
         rf_wr.wr = 1'b0;
         rf_wr.fw = 1'b0;
      end
   end

   chip8ie_regfile u_regfile (
      .clock (clock),
      .reset (reset),
      .rd_en (req_fire),
      .rd_x  (req_ch.opcode[11:8]),
      .rd_y  (req_ch.opcode[7:4]),
      .wr    (rf_wr),
      .vx    (vx),
      .vy    (vy),
      .v0    (v0)
   );

   chip8ie_stack #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_stack (
      .clock     (clock),
      .reset     (reset),
      .push      (exec_fire && ex.push),
      .pop       (exec_fire && ex.pop),
      .push_data (ex.link_pc),
      .top       (stack_top)
   );

   chip8ie_alu u_alu (
      .opcode      (op_ff),
      .random_byte (rnd_ff),
      .vx          (vx),
      .vy          (vy),
      .v0          (v0),
      .pc          (pc_ff),
      .index       (index_ff),
      .stack_top   (stack_top),
      .ex          (ex)
   );

   // Result payload assembled from the execute stage.
   always_comb begin
      rsp_in.next_pc      = ex.next_pc;
      rsp_in.index_value  = ex.index;
      rsp_in.reg_written  = ex.rf.wr;
      rsp_in.reg_number   = ex.rf.x;
      rsp_in.reg_value    = ex.rf.res;
      rsp_in.flag_written = ex.rf.fw;
      rsp_in.flag_value   = ex.rf.fw & ex.rf.flag;
      rsp_in.unhandled    = ex.unh;
   end

   always_ff @(posedge clock) begin
      if (exec_fire) begin
         rsp_ff <= rsp_in;
      end
   end

   // Control state: stage valids, pc and index register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         pc_ff        <= chip8ie_pkg::PC_RESET;
         index_ff     <= 16'd0;
      end else begin
         if (req_fire) begin
            in_valid_ff <= 1'b1;
         end else if (exec_fire) begin
            in_valid_ff <= 1'b0;
         end
         if (exec_fire) begin
            rsp_valid_ff <= 1'b1;
            pc_ff        <= ex.next_pc;
            index_ff     <= ex.index;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.next_pc      = rsp_ff.next_pc;
   assign rsp_ch.index_value  = rsp_ff.index_value;
   assign rsp_ch.reg_written  = rsp_ff.reg_written;
   assign rsp_ch.reg_number   = rsp_ff.reg_number;
   assign rsp_ch.reg_value    = rsp_ff.reg_value;
   assign rsp_ch.flag_written = rsp_ff.flag_written;
   assign rsp_ch.flag_value   = rsp_ff.flag_value;
   assign rsp_ch.unhandled    = rsp_ff.unhandled;

   // A full input stage that cannot execute must refuse new items.
   `C8IE_ASSERT_IMP(a_in_hold, clock, reset, in_valid_ff && !exec_fire, !req_ch.ready, "input stage overrun")
   // Every executed instruction leaves a result item behind.
   `C8IE_ASSERT_NEXT(a_exec_rsp, clock, reset, exec_fire, rsp_valid_ff, "executed item lost")
   // The result register tracks the pc and index registers.
   `C8IE_ASSERT_IMP(a_rsp_state, clock, reset, rsp_valid_ff, rsp_ff.next_pc == pc_ff && rsp_ff.index_value == index_ff, "result disagrees with state")
   // An unhandled opcode writes no register and no flag.
   `C8IE_ASSERT_IMP(a_unh_quiet, clock, reset, exec_fire && ex.unh, !rf_wr.wr && !rf_wr.fw, "unhandled opcode wrote state")

endmodule

### tb/chip8_instruction_execute_checker.sv
// Checker for the CHIP-8 execute block: mirrors the architectural state and compares results.
// Depends on chip8ie_pkg and the channel interfaces in chip8ie_if.
module chip8_instruction_execute_checker
   import chip8ie_pkg::*;
#(
   parameter int STACK_DEPTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   chip8ie_req_if      req_ch,
   chip8ie_rsp_if      rsp_ch,
   output int unsigned error_count,
   output int unsigned results_pending,
   output int unsigned results_checked
);

   localparam int unsigned MAX_REPORTS = 200;

   // One predicted outcome, kept with the opcode that caused it for the report.
   typedef struct {
      logic [15:0] opcode;
      rsp_type     outcome;
   } outcome_entry;

   // Mirror of the architectural state.
   logic [7:0]  v_reg [16];
   logic [15:0] index_reg;
   logic [11:0] pc_reg;
   logic [11:0] return_stack [STACK_DEPTH];
   int unsigned stack_slot;

   outcome_entry outcome_fifo [$];
   int unsigned  mismatches = 0;
   int unsigned  compared = 0;

   // Executes one opcode against the mirror state and returns the result item it yields.
   task execute_opcode(input logic [15:0] op, input logic [7:0] rnd, output rsp_type outcome);
      logic [3:0]  hi, x, y, n;
      logic [11:0] nnn, pc_new;
      logic [7:0]  kk, vx, vy, value;
      logic        skip, wr, fw, flag, unh;
      hi = op[15:12];
      x = op[11:8];
      y = op[7:4];
      n = op[3:0];
      nnn = op[11:0];
      kk = op[7:0];
      vx = v_reg[x];
      vy = v_reg[y];
      pc_new = pc_reg + PC_STEP;
      skip = 1'b0;
      wr = 1'b0;
      fw = 1'b0;
      flag = 1'b0;
      unh = 1'b0;
      value = '0;
      case (hi)
         OP_SYS: begin
            if (nnn == NNN_RET) begin
               stack_slot = (stack_slot + STACK_DEPTH - 1) % STACK_DEPTH;
               pc_new = return_stack[stack_slot];
            end else begin
               unh = 1'b1;
            end
         end
         OP_JP: pc_new = nnn;
         OP_CALL: begin
            return_stack[stack_slot] = pc_new;
            stack_slot = (stack_slot + 1) % STACK_DEPTH;
            pc_new = nnn;
         end
         OP_SE_KK: skip = (vx == kk);
         OP_SN_KK: skip = (vx != kk);
         OP_SE_XY: skip = (vx == vy);
         OP_SN_XY: skip = (vx != vy);
         OP_LD_KK: begin
            wr = 1'b1;
            value = kk;
         end
         OP_AD_KK: begin
            wr = 1'b1;
            value = vx + kk;
         end
         OP_ALU: begin
            wr = 1'b1;
            case (n)
               ALU_MOV: value = vy;
               ALU_OR:  value = vx | vy;
               ALU_AND: value = vx & vy;
               ALU_XOR: value = vx ^ vy;
               ALU_ADD: begin
                  {flag, value} = {1'b0, vx} + {1'b0, vy};
                  fw = 1'b1;
               end
               ALU_SUB: begin
                  value = vx - vy;
                  flag = (vx >= vy);
                  fw = 1'b1;
               end
               ALU_SHR: begin
                  value = vx >> 1;
                  flag = vx[0];
                  fw = 1'b1;
               end
               ALU_SBN: begin
                  value = vy - vx;
                  flag = (vy >= vx);
                  fw = 1'b1;
               end
               ALU_SHL: begin
                  value = vx << 1;
                  flag = vx[7];
                  fw = 1'b1;
               end
               default: begin
                  wr = 1'b0;
                  unh = 1'b1;
               end
            endcase
         end
         OP_LD_I: index_reg = {4'h0, nnn};
         OP_JP_V0: pc_new = v_reg[REG_V0] + nnn;
         OP_RND: begin
            wr = 1'b1;
            value = rnd & kk;
         end
         OP_MISC: begin
            if (kk == KK_ADD_I) begin
               index_reg = index_reg + vx;
            end else begin
               unh = 1'b1;
            end
         end
         default: unh = 1'b1;
      endcase

      // The flag goes to VF after the result, so it wins when x is VF.
      if (skip) begin
         pc_new = pc_reg + PC_SKIP;
      end
      if (wr) begin
         v_reg[x] = value;
      end
      if (fw) begin
         v_reg[REG_VF] = {7'b0, flag};
      end
      pc_reg = pc_new;

      outcome.next_pc = pc_reg;
      outcome.index_value = index_reg;
      outcome.reg_written = wr;
      outcome.reg_number = wr ? x : 4'h0;
      outcome.reg_value = wr ? value : 8'h00;
      outcome.flag_written = fw;
      outcome.flag_value = fw & flag;
      outcome.unhandled = unh;
   endtask

   // Compares one field and reports it when it differs.
   task compare_field(input string field, input logic [15:0] opcode,
                      input logic [15:0] expected_value, input logic [15:0] actual_value);
      if (expected_value !== actual_value) begin
         mismatches++;
         if (mismatches <= MAX_REPORTS) begin
            $display("%0t: opcode 0x%04h %s expected 0x%0h actual 0x%0h",
                     $time, opcode, field, expected_value, actual_value);
         end
      end
   endtask

   // Predict on every accepted opcode, compare on every accepted result.
   always @(posedge clock) begin
      rsp_type      predicted;
      outcome_entry entry;
      if (reset) begin
         for (int i = 0; i < 16; i++) begin
            v_reg[i] = 8'h00;
         end
         for (int i = 0; i < STACK_DEPTH; i++) begin
            return_stack[i] = 12'h000;
         end
         index_reg = 16'h0000;
         pc_reg = PC_RESET;
         stack_slot = 0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            execute_opcode(req_ch.opcode, req_ch.random_byte, predicted);
            entry.opcode = req_ch.opcode;
            entry.outcome = predicted;
            outcome_fifo.push_back(entry);
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (outcome_fifo.size() == 0) begin
               mismatches++;
               $display("%0t: result item with no instruction pending, expected none actual pc 0x%03h",
                        $time, rsp_ch.next_pc);
            end else begin
               entry = outcome_fifo.pop_front();
               compared++;
               compare_field("next_pc", entry.opcode, 16'(entry.outcome.next_pc),
                             16'(rsp_ch.next_pc));
               compare_field("index_value", entry.opcode, entry.outcome.index_value,
                             rsp_ch.index_value);
               compare_field("reg_written", entry.opcode, 16'(entry.outcome.reg_written),
                             16'(rsp_ch.reg_written));
               compare_field("reg_number", entry.opcode, 16'(entry.outcome.reg_number),
                             16'(rsp_ch.reg_number));
               compare_field("reg_value", entry.opcode, 16'(entry.outcome.reg_value),
                             16'(rsp_ch.reg_value));
               compare_field("flag_written", entry.opcode, 16'(entry.outcome.flag_written),
                             16'(rsp_ch.flag_written));
               compare_field("flag_value", entry.opcode, 16'(entry.outcome.flag_value),
                             16'(rsp_ch.flag_value));
               compare_field("unhandled", entry.opcode, 16'(entry.outcome.unhandled),
                             16'(rsp_ch.unhandled));
            end
         end
      end
      error_count <= mismatches;
      results_pending <= outcome_fifo.size();
      results_checked <= compared;
   end

endmodule

### tb/chip8_instruction_execute_test.sv
// Top of the CHIP-8 execute block test: clock, reset, opcode stream, output stalls and verdict.
// Depends on chip8ie_pkg, chip8ie_if, the block itself and chip8_instruction_execute_checker.
module chip8_instruction_execute_test;
   import chip8ie_pkg::*;

   localparam int          STACK_SLOTS = 16;
   localparam int unsigned ITEM_TARGET = 950;
   localparam int unsigned IDLE_LIMIT = 5000;
   localparam int unsigned DRAIN_CYCLES = 8;
   localparam int unsigned HOLD_START = 700;
   localparam int unsigned HOLD_CYCLES = 200;
   localparam int unsigned WALK_LENGTH = 245;
   localparam int          DIRECTED_COUNT = 29;
   localparam logic [11:0] NNN_CLEAR = 12'h0E0;

   logic clock = 1'b0;
   logic reset = 1'b1;

   chip8ie_req_if req_ch();
   chip8ie_rsp_if rsp_ch();

   int unsigned       error_count;
   int unsigned       results_pending;
   int unsigned       results_checked;
   int unsigned       opcodes_sent = 0;
   int unsigned       call_count = 0;
   int unsigned       return_count = 0;
   int unsigned       stack_wraps = 0;
   int unsigned       burst_left = 0;
   int unsigned       idle_cycles = 0;
   int unsigned       stack_level = 0;
   bit [STACK_SLOTS-1:0] slot_written = '0;

   // Edge values, both operation groups, flag on VF, unhandled ops, pc wrap.
   logic [15:0] directed_ops [DIRECTED_COUNT] = '{
      16'h60FF, 16'h6101, 16'h3101, 16'h4100, 16'h5007, 16'h9010, 16'h8014, 16'h8015,
      16'h8017, 16'h6E80, 16'h8E0E, 16'h8106, 16'h6FFF, 16'h8F14, 16'h8121, 16'h8122,
      16'h8123, 16'h8120, 16'h812B, 16'h00E0, 16'hD123, 16'hF107, 16'hAFFF, 16'hF01E,
      16'h2ABC, 16'h00EE, 16'h1FFE, 16'hC3F0, 16'hBFFF
   };

   always #5 clock = ~clock;

   chip8_instruction_execute #(
      .STACK_DEPTH(STACK_SLOTS)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .req_ch(req_ch),
      .rsp_ch(rsp_ch)
   );

   chip8_instruction_execute_checker #(
      .STACK_DEPTH(STACK_SLOTS)
   ) i_checker (
      .clock(clock),
      .reset(reset),
      .req_ch(req_ch),
      .rsp_ch(rsp_ch),
      .error_count(error_count),
      .results_pending(results_pending),
      .results_checked(results_checked)
   );

   // Register numbers lean toward V0..V3 so that compares hit equal values often.
   function automatic logic [3:0] pick_reg();
      logic [3:0] r;
      if ($urandom_range(0, 1) == 0) begin
         r = 4'($urandom_range(0, 3));
      end else begin
         r = 4'($urandom_range(0, 15));
      end
      return r;
   endfunction

   // Immediates lean toward the carry and borrow boundaries.
   function automatic logic [7:0] pick_byte();
      logic [7:0] b;
      case ($urandom_range(0, 7))
         0: b = 8'h00;
         1: b = 8'hFF;
         2: b = 8'h01;
         3: b = 8'h80;
         default: b = 8'($urandom());
      endcase
      return b;
   endfunction

   // Builds one opcode from any group with fields shaped to reach the interesting cases.
   function automatic logic [15:0] make_opcode();
      logic [3:0]  hi, x, y, n;
      logic [7:0]  kk;
      logic [15:0] op;
      hi = 4'($urandom_range(0, 15));
      x = pick_reg();
      y = pick_reg();
      kk = pick_byte();
      n = 4'($urandom());
      case (hi)
         OP_SYS: begin
            case ($urandom_range(0, 2))
               0: op = {OP_SYS, NNN_CLEAR};
               1: op = {OP_SYS, NNN_RET};
               default: op = {OP_SYS, 12'($urandom())};
            endcase
         end
         OP_ALU: begin
            case ($urandom_range(0, 10))
               0: n = ALU_MOV;
               1: n = ALU_OR;
               2: n = ALU_AND;
               3: n = ALU_XOR;
               4: n = ALU_ADD;
               5: n = ALU_SUB;
               6: n = ALU_SHR;
               7: n = ALU_SBN;
               8: n = ALU_SHL;
               default: n = 4'($urandom());
            endcase
            op = {OP_ALU, x, y, n};
         end
         OP_MISC: op = {OP_MISC, x, ($urandom_range(0, 2) != 0) ? KK_ADD_I : kk};
         OP_SE_KK, OP_SN_KK, OP_LD_KK, OP_AD_KK, OP_RND: op = {hi, x, kk};
         OP_JP, OP_CALL, OP_LD_I, OP_JP_V0: op = {hi, 12'($urandom())};
         default: op = {hi, x, y, n};
      endcase
      return op;
   endfunction

   // Offers one opcode in bursts with random gaps; a return only pops a slot already pushed.
   task automatic offer(input logic [15:0] opcode_in);
      logic [15:0] op;
      int unsigned gap;
      op = opcode_in;
      if (op == {OP_SYS, NNN_RET} &&
          !slot_written[(stack_level + STACK_SLOTS - 1) % STACK_SLOTS]) begin
         op = {OP_SYS, NNN_CLEAR};
      end
      if (op[15:12] == OP_CALL) begin
         slot_written[stack_level] = 1'b1;
         if (stack_level == STACK_SLOTS - 1) begin
            stack_wraps++;
         end
         stack_level = (stack_level + 1) % STACK_SLOTS;
         call_count++;
      end else if (op == {OP_SYS, NNN_RET}) begin
         if (stack_level == 0) begin
            stack_wraps++;
         end
         stack_level = (stack_level + STACK_SLOTS - 1) % STACK_SLOTS;
         return_count++;
      end

      // A new burst may start after a gap; a zero gap keeps valid high.
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap != 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 16);
      end
      req_ch.valid <= 1'b1;
      req_ch.opcode <= op;
      req_ch.random_byte <= 8'($urandom());
      do @(posedge clock); while (!req_ch.ready);
      burst_left--;
      opcodes_sent++;
   endtask

   // Nested calls, sometimes past the stack depth, then the matching returns.
   task automatic run_call_nest(input int unsigned depth);
      repeat (depth) begin
         offer({OP_CALL, 12'($urandom())});
         if ($urandom_range(0, 1) == 0) begin
            offer(make_opcode());
         end
      end
      repeat (depth) begin
         offer({OP_SYS, NNN_RET});
         if ($urandom_range(0, 2) == 0) begin
            offer(make_opcode());
         end
      end
   endtask

   // Loads a register, then tests and operates on it.
   task automatic run_register_test();
      logic [3:0] x;
      logic [7:0] kk;
      x = pick_reg();
      kk = pick_byte();
      offer({OP_LD_KK, x, kk});
      offer({($urandom_range(0, 1) == 0) ? OP_SE_KK : OP_SN_KK, x,
             ($urandom_range(0, 1) == 0) ? kk : pick_byte()});
      offer({($urandom_range(0, 1) == 0) ? OP_SE_XY : OP_SN_XY, x, pick_reg(), 4'($urandom())});
      offer({OP_ALU, x, pick_reg(), ($urandom_range(0, 1) == 0) ? ALU_SUB : ALU_SBN});
   endtask

   // Output side: stall patterns in segments, with one long hold while input keeps coming.
   initial begin
      int unsigned cycle_count;
      int unsigned seg_left;
      int unsigned mode;
      bit          held;
      cycle_count = 0;
      seg_left = 0;
      mode = 0;
      held = 1'b0;
      rsp_ch.ready = 1'b0;
      while (reset) @(posedge clock);
      forever begin
         @(posedge clock);
         cycle_count++;
         if (!held && cycle_count == HOLD_START) begin
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            held = 1'b1;
         end
         if (seg_left == 0) begin
            mode = $urandom_range(0, 2);
            seg_left = $urandom_range(10, 60);
         end
         seg_left--;
         case (mode)
            0: rsp_ch.ready <= 1'b1;
            1: rsp_ch.ready <= ($urandom_range(0, 9) < 6);
            default: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
         endcase
      end
   end

   // Ends the run when no item moves on either channel for too long.
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("%0t: no item moved for %0d cycles", $time, idle_cycles);
         $display("CHECKS FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Opcode stream: directed opening, then mixed random sequences, then drain and verdict.
   initial begin
      bit walk_done;
      walk_done = 1'b0;
      req_ch.valid = 1'b0;
      req_ch.opcode = 16'h0000;
      req_ch.random_byte = 8'h00;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < DIRECTED_COUNT; i++) begin
         offer(directed_ops[i]);
      end

      while (opcodes_sent < ITEM_TARGET) begin
         case ($urandom_range(0, 9))
            0: run_call_nest($urandom_range(1, 18));
            1, 2: run_register_test();
            3: offer(16'($urandom()));
            default: offer(make_opcode());
         endcase

         // Walk the index register past its top so that the add wraps.
         if (!walk_done && opcodes_sent > 300) begin
            offer({OP_LD_KK, 4'h5, 8'hFF});
            offer({OP_LD_I, 12'hFFF});
            repeat (WALK_LENGTH) offer({OP_MISC, 4'h5, KK_ADD_I});
            walk_done = 1'b1;
         end
      end
      req_ch.valid <= 1'b0;

      do @(posedge clock); while (results_pending != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Executed %0d opcodes with %0d calls, %0d returns and %0d call stack wraps.",
               opcodes_sent, call_count, return_count, stack_wraps);
      $display("Compared %0d results, including a %0d-cycle output hold with input backed up.",
               results_checked, HOLD_CYCLES);
      if (error_count == 0 && results_pending == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

### chip8_instruction_execute.f
+incdir+rtl/core
rtl/core/chip8ie_pkg.sv
rtl/core/chip8ie_if.sv
rtl/core/chip8ie_regfile.sv
rtl/core/chip8ie_stack.sv
rtl/core/chip8ie_alu.sv
rtl/core/chip8_instruction_execute.sv
tb/chip8_instruction_execute_checker.sv
tb/chip8_instruction_execute_test.sv
